// File: hw/rtl/yuvrot_pkg.sv
// Shared constants, register codes and helpers for the YUV to RGBA rotate stream.
package yuvrot_pkg;

    // Field widths
    localparam int SAMPLE_W   = 8;
    localparam int SIZE_CFG_W = 13;
    localparam int TURNS_W    = 2;
    localparam int INDEX_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 3 * SAMPLE_W;
    localparam int OUT_DATA_W = 4 * SAMPLE_W + INDEX_W;

    // Default parameter values
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Register reset values
    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_QUARTER_TURNS = 2'd2
    } cfg_reg_t;

    // Rotation codes
    typedef enum logic [TURNS_W-1:0] {
        TURN_0   = 2'd0,
        TURN_90  = 2'd1,
        TURN_180 = 2'd2,
        TURN_270 = 2'd3
    } turns_t;

    // BT.601 studio-range conversion, 21-bit signed sums
    localparam int SUM_W = 21;
    localparam logic signed [SUM_W-1:0] K_Y    = 21'sd298;
    localparam logic signed [SUM_W-1:0] K_RV   = 21'sd409;
    localparam logic signed [SUM_W-1:0] K_GU   = 21'sd100;
    localparam logic signed [SUM_W-1:0] K_GV   = 21'sd208;
    localparam logic signed [SUM_W-1:0] K_BU   = 21'sd516;
    localparam logic signed [SUM_W-1:0] K_RND  = 21'sd128;
    localparam logic signed [SUM_W-1:0] OFS_Y  = 21'sd16;
    localparam logic signed [SUM_W-1:0] OFS_UV = 21'sd128;
    localparam logic [SAMPLE_W-1:0]     ALPHA_OPAQUE = 8'd255;

    // Drop the rounding fraction and clamp to 0..255
    function automatic logic [SAMPLE_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] s);
        logic [SAMPLE_W-1:0] r;
        if (s[SUM_W-1]) begin
            r = '0;
        end else if (s[SUM_W-2:16] != '0) begin
            r = 8'd255;
        end else begin
            r = s[15:8];
        end
        return r;
    endfunction

    // Widen a sample to a signed sum and remove its offset
    function automatic logic signed [SUM_W-1:0] centered(input logic [SAMPLE_W-1:0] v,
                                                          input logic signed [SUM_W-1:0] ofs);
        return $signed({{(SUM_W-SAMPLE_W){1'b0}}, v}) - ofs;
    endfunction

endpackage

// File: hw/rtl/yuv_to_rgba_rotate_stream.sv
// Top level: BT.601 YUV to RGBA conversion with rotated destination index.
// Path from input accept to result valid: input register, then result register.
// Throughput: 1 item per cycle unless m_tready stalls; the multiply-add for the index
// and the channel sums sit between the input register and the result register.
// Reset (aresetn low, synchronous): width 640, height 480, no rotation, counters
// at zero, both pipeline stages empty.
module yuv_to_rgba_rotate_stream #(
    parameter int MAX_WIDTH  = yuvrot_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = yuvrot_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input item
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [yuvrot_pkg::IN_DATA_W-1:0]     s_tdata,   // luma, chroma_u, chroma_v
    // result item
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [yuvrot_pkg::OUT_DATA_W-1:0]    m_tdata,   // red, green, blue, alpha,
                                                            // dest_index
    output logic                                 m_tlast,   // frame_end
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [yuvrot_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [yuvrot_pkg::SIZE_CFG_W-1:0]    cfg_data
);
    import yuvrot_pkg::*;

    // Column/row counter widths and effective size widths
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    // Operand widths for the index multiply-add (either orientation)
    localparam int AW  = (CW > RW) ? CW : RW;
    localparam int BW  = (WW > HW) ? WW : HW;
    localparam int PW0 = AW + BW + 1;
    localparam int PW  = (PW0 > INDEX_W) ? PW0 : INDEX_W;

    localparam logic [WW-1:0] W_RESET = WW'((RST_WIDTH  > MAX_WIDTH)  ? MAX_WIDTH  : RST_WIDTH);
    localparam logic [HW-1:0] H_RESET = HW'((RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT);
    localparam logic [WW-1:0] W_MAX   = WW'(MAX_WIDTH);
    localparam logic [HW-1:0] H_MAX   = HW'(MAX_HEIGHT);

    // Configuration: sizes are held already saturated to 1..MAX
    logic [WW-1:0]      width_reg;
    logic [HW-1:0]      height_reg;
    logic [TURNS_W-1:0] turns_reg;

    // Position of the next pixel
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // Input register stage
    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_luma_reg, s1_u_reg, s1_v_reg;
    logic [CW-1:0]       s1_x_reg, s1_xr_reg;
    logic [RW-1:0]       s1_y_reg, s1_yr_reg;
    logic [WW-1:0]       s1_w_reg;
    logic [HW-1:0]       s1_h_reg;
    logic [TURNS_W-1:0]  s1_turns_reg;
    logic                s1_last_reg;

    // Result register stage
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                  m_last_reg;

    logic s_fire, cfg_fire, s2_adv, s1_load;

    // Current position clamped into the frame, and its mirror
    logic [CW-1:0] x_c, x_rev;
    logic [RW-1:0] y_c, y_rev;
    logic          last_col, last_row;

    // Stage 2 arithmetic
    logic signed [SUM_W-1:0] c_s, d_s, e_s, sum_r, sum_g, sum_b;
    logic [AW-1:0]           mul_a, add_c;
    logic [BW-1:0]           mul_b;
    logic [PW-1:0]           idx_full;

    // Take no write while reset is held
    assign cfg_ready = aresetn;
    assign cfg_fire  = cfg_valid & cfg_ready;

    // Advance the result stage when it is empty or being drained; the input
    // stage moves whenever the result stage can take its content.
    assign s2_adv   = !m_valid_reg || m_tready;
    assign s_tready = aresetn && (!s1_valid_reg || s2_adv);
    assign s_fire   = s_tvalid & s_tready;
    assign s1_load  = s_tready;

    // Clamp position (only guards against sizes shrinking below the counters)
    always_comb begin
        x_c      = (WW'(col_reg) >= width_reg)  ? CW'(width_reg - 1'b1)  : col_reg;
        y_c      = (HW'(row_reg) >= height_reg) ? RW'(height_reg - 1'b1) : row_reg;
        x_rev    = CW'(width_reg - 1'b1 - WW'(x_c));
        y_rev    = RW'(height_reg - 1'b1 - HW'(y_c));
        last_col = (WW'(x_c) == width_reg - 1'b1);
        last_row = (HW'(y_c) == height_reg - 1'b1);
    end

    // Raster walk: wrap the column at the row end and the row at the frame end
    always_comb begin
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : RW'(y_c + 1'b1);
        end else begin
            col_next = CW'(x_c + 1'b1);
            row_next = y_c;
        end
    end

    // Configuration registers and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= W_RESET;
            height_reg <= H_RESET;
            turns_reg  <= TURN_0;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_FRAME_WIDTH: begin
                    if (cfg_data == '0) begin
                        width_reg <= WW'(1);
                    end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
                        width_reg <= W_MAX;
                    end else begin
                        width_reg <= WW'(cfg_data);
                    end
                    // restart the frame
                    col_reg <= '0;
                    row_reg <= '0;
                end
                REG_FRAME_HEIGHT: begin
                    if (cfg_data == '0) begin
                        height_reg <= HW'(1);
                    end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
                        height_reg <= H_MAX;
                    end else begin
                        height_reg <= HW'(cfg_data);
                    end
                    col_reg <= '0;
                    row_reg <= '0;
                end
                REG_QUARTER_TURNS: begin
                    turns_reg <= cfg_data[TURNS_W-1:0];
                    // keep the raster walking
                    if (s_fire) begin
                        col_reg <= col_next;
                        row_reg <= row_next;
                    end
                end
                default: begin
                    // writes beyond the register list are dropped
                    if (s_fire) begin
                        col_reg <= col_next;
                        row_reg <= row_next;
                    end
                end
            endcase
        end else if (s_fire) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Input register: capture the samples with the geometry of this pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_load) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_luma_reg  <= s_tdata[SAMPLE_W-1:0];
            s1_u_reg     <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            s1_v_reg     <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
            s1_x_reg     <= x_c;
            s1_y_reg     <= y_c;
            s1_xr_reg    <= x_rev;
            s1_yr_reg    <= y_rev;
            s1_w_reg     <= width_reg;
            s1_h_reg     <= height_reg;
            s1_turns_reg <= turns_reg;
            s1_last_reg  <= last_col & last_row;
        end
    end

    // Color conversion: three constant-coefficient sums, then clamp
    always_comb begin
        c_s   = centered(s1_luma_reg, OFS_Y);
        d_s   = centered(s1_u_reg, OFS_UV);
        e_s   = centered(s1_v_reg, OFS_UV);
        sum_r = K_Y * c_s + K_RV * e_s + K_RND;
        sum_g = K_Y * c_s - K_GU * d_s - K_GV * e_s + K_RND;
        sum_b = K_Y * c_s + K_BU * d_s + K_RND;
    end

    // Destination index: one multiply-add, operands picked by the rotation
    always_comb begin
        case (turns_t'(s1_turns_reg))
            TURN_90: begin
                mul_a = AW'(s1_x_reg);
                mul_b = BW'(s1_h_reg);
                add_c = AW'(s1_yr_reg);
            end
            TURN_180: begin
                mul_a = AW'(s1_yr_reg);
                mul_b = BW'(s1_w_reg);
                add_c = AW'(s1_xr_reg);
            end
            TURN_270: begin
                mul_a = AW'(s1_xr_reg);
                mul_b = BW'(s1_h_reg);
                add_c = AW'(s1_y_reg);
            end
            default: begin
                mul_a = AW'(s1_y_reg);
                mul_b = BW'(s1_w_reg);
                add_c = AW'(s1_x_reg);
            end
        endcase
        idx_full    = PW'(mul_a) * PW'(mul_b) + PW'(add_c);
        m_data_next = {idx_full[INDEX_W-1:0], ALPHA_OPAQUE,
                       clamp_channel(sum_b), clamp_channel(sum_g), clamp_channel(sum_r)};
    end

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv && s1_valid_reg) begin
            m_data_reg <= m_data_next;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
